/* rtl/stop_and_wait_arq_sender_core_macros.svh */
// Assertion macros shared by the stop-and-wait ARQ sender modules.
`ifndef STOP_AND_WAIT_ARQ_SENDER_CORE_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAW_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAW_ASSERT(label, expr, msg)
`define SAW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/sawarq_pkg.sv */
// Types, constants and codes of the stop-and-wait ARQ sender.
package sawarq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SEQ_BITS    = 16;
  localparam int TAG_BITS    = 16;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [QIDX_W-1:0]   qidx_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [CMP_W-1:0]    cmp_t;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_TXDONE = 2'd1,
    OP_ACK    = 2'd2,
    OP_NACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_RESEND = 2'd2,
    ACT_DROP   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SENDING = 2'd1,
    ST_WAITING = 2'd2
  } st_t;

  localparam logic REG_QUEUE_LIMIT = 1'b0;
  localparam logic REG_HEADER_BITS = 1'b1;

  // Classified event handed from front to back.
  typedef struct packed {
    logic        is_new;
    logic        is_txdone;
    logic        is_ack;
    logic        is_nack;
    tag_t        tag;
    logic [15:0] bits;
    seq_t        aseq;
  } evt_t;

  typedef struct packed {
    act_t        action;
    logic [15:0] frame_seq;
    logic [15:0] frame_tag;
    logic [16:0] frame_bits;
    logic [1:0]  state_now;
    logic [4:0]  queue_count;
    logic [15:0] repeat_count;
    logic [31:0] sent_packets;
    logic [31:0] sent_bits;
    logic [31:0] lost_packets;
    logic [31:0] ack_count;
    logic [31:0] nack_count;
  } result_t;

endpackage

/* rtl/sawarq_front.sv */
// Front end: decodes input beats and buffers them in a two-entry event queue.
`include "stop_and_wait_arq_sender_core_macros.svh"
module sawarq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,
  input  logic [7:0]         in_tuser,
  output logic               evt_valid,
  input  logic               evt_ready,
  output sawarq_pkg::evt_t   evt
);

  sawarq_pkg::evt_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  sawarq_pkg::evt_t dec;
  sawarq_pkg::op_t  op;
  logic             push, pop;

  always_comb begin
    op            = sawarq_pkg::op_t'(in_tuser[1:0]);
    dec.is_new    = (op == sawarq_pkg::OP_NEW);
    dec.is_txdone = (op == sawarq_pkg::OP_TXDONE);
    dec.is_ack    = (op == sawarq_pkg::OP_ACK);
    dec.is_nack   = (op == sawarq_pkg::OP_NACK);
    dec.tag       = sawarq_pkg::tag_t'(in_tdata[15:0]);
    dec.bits      = in_tdata[31:16];
    dec.aseq      = sawarq_pkg::seq_t'(in_tdata[47:32]);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign evt_valid = (cnt_r != 2'd0);
  assign evt       = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = evt_valid && evt_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  `SAW_ASSERT(a_front_cnt_max, cnt_r <= 2'd2, "event queue over two entries")
  `SAW_ASSERT_NEXT(a_front_push_grows, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
  `SAW_ASSERT(a_front_ptr_sync, (cnt_r != 2'd0) || (wr_ptr_r == rd_ptr_r), "empty ptr mismatch")

endmodule

/* rtl/sawarq_back.sv */
// Back end: link state machine, pending packet queue, counters, result register.
`include "stop_and_wait_arq_sender_core_macros.svh"
module sawarq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [9:0]            cfg_wdata,
  input  logic                  evt_valid,
  output logic                  evt_ready,
  input  sawarq_pkg::evt_t      evt,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output sawarq_pkg::result_t   out_res
);

  logic [4:0]          queue_limit_r;
  logic [9:0]          header_bits_r;

  sawarq_pkg::st_t     state_r, state_nxt;
  sawarq_pkg::tag_t    pend_tag_r  [sawarq_pkg::QUEUE_DEPTH];
  logic [15:0]         pend_bits_r [sawarq_pkg::QUEUE_DEPTH];
  sawarq_pkg::qidx_t   head_r, head_nxt;
  sawarq_pkg::qidx_t   tail_r, tail_nxt;
  sawarq_pkg::fill_t   fill_r, fill_nxt;
  sawarq_pkg::seq_t    seq_r, seq_nxt;
  sawarq_pkg::tag_t    tag_r, tag_nxt;
  logic [15:0]         bits_r, bits_nxt;
  logic [15:0]         rep_r, rep_nxt;
  logic [31:0]         sent_pkt_r, sent_pkt_nxt;
  logic [31:0]         sent_bits_r, sent_bits_nxt;
  logic [31:0]         lost_r, lost_nxt;
  logic [31:0]         ack_r, ack_nxt;
  logic [31:0]         nack_r, nack_nxt;

  logic                out_valid_r, out_valid_nxt;
  sawarq_pkg::result_t res_r, res_nxt;

  logic                fire, match, full;
  logic                do_new, do_push, do_drop, do_resend, do_ack, do_pop;
  sawarq_pkg::cmp_t    limit;
  sawarq_pkg::act_t    act;

  assign evt_ready  = !out_valid_r || out_tready;
  assign fire       = evt_valid && evt_ready;
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  // Event decode against current link state
  always_comb begin
    limit = (sawarq_pkg::cmp_t'(queue_limit_r) > sawarq_pkg::cmp_t'(sawarq_pkg::QUEUE_DEPTH))
          ? sawarq_pkg::cmp_t'(sawarq_pkg::QUEUE_DEPTH) : sawarq_pkg::cmp_t'(queue_limit_r);
    full      = sawarq_pkg::cmp_t'(fill_r) >= limit;
    match     = (state_r == sawarq_pkg::ST_WAITING) && (evt.aseq == seq_r);
    do_new    = evt.is_new && (state_r == sawarq_pkg::ST_IDLE);
    do_drop   = evt.is_new && (state_r != sawarq_pkg::ST_IDLE) && full;
    do_push   = evt.is_new && (state_r != sawarq_pkg::ST_IDLE) && !full;
    do_resend = evt.is_nack && match;
    do_ack    = evt.is_ack && match;
    do_pop    = do_ack && (fill_r != '0);
  end

  // Next link state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sawarq_pkg::ST_IDLE: begin
        if (do_new) state_nxt = sawarq_pkg::ST_SENDING;
      end
      sawarq_pkg::ST_SENDING: begin
        if (evt.is_txdone) state_nxt = sawarq_pkg::ST_WAITING;
      end
      sawarq_pkg::ST_WAITING: begin
        if (do_resend || do_pop) state_nxt = sawarq_pkg::ST_SENDING;
        else if (do_ack)         state_nxt = sawarq_pkg::ST_IDLE;
      end
      default: state_nxt = sawarq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    seq_nxt       = seq_r;
    tag_nxt       = tag_r;
    bits_nxt      = bits_r;
    rep_nxt       = rep_r;
    sent_pkt_nxt  = sent_pkt_r;
    sent_bits_nxt = sent_bits_r;
    lost_nxt      = lost_r;
    ack_nxt       = ack_r;
    nack_nxt      = nack_r;
    act           = sawarq_pkg::ACT_NONE;

    if (do_push) begin
      tail_nxt = (tail_r == sawarq_pkg::qidx_t'(sawarq_pkg::QUEUE_DEPTH - 1))
               ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
    if (do_drop) begin
      lost_nxt = lost_r + 32'd1;
      act      = sawarq_pkg::ACT_DROP;
    end
    if (do_resend) begin
      if (rep_r != 16'hFFFF) rep_nxt = rep_r + 16'd1;
      nack_nxt = nack_r + 32'd1;
      act      = sawarq_pkg::ACT_RESEND;
    end
    if (do_ack) begin
      ack_nxt = ack_r + 32'd1;
      if (!do_pop) rep_nxt = 16'd0;
    end
    if (do_pop) begin
      head_nxt = (head_r == sawarq_pkg::qidx_t'(sawarq_pkg::QUEUE_DEPTH - 1))
               ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
    // New frame, from the input beat or from the queue head
    if (do_new || do_pop) begin
      seq_nxt       = seq_r + 1'b1;
      tag_nxt       = do_new ? evt.tag : pend_tag_r[head_r];
      bits_nxt      = do_new ? evt.bits : pend_bits_r[head_r];
      rep_nxt       = 16'd1;
      sent_pkt_nxt  = sent_pkt_r + 32'd1;
      sent_bits_nxt = sent_bits_r + {16'd0, bits_nxt};
      act           = sawarq_pkg::ACT_SEND;
    end

    res_nxt              = '0;
    res_nxt.action       = act;
    if ((act == sawarq_pkg::ACT_SEND) || (act == sawarq_pkg::ACT_RESEND)) begin
      res_nxt.frame_seq  = 16'(seq_nxt);
      res_nxt.frame_tag  = 16'(tag_nxt);
      res_nxt.frame_bits = {7'd0, header_bits_r} + {1'b0, bits_nxt};
    end
    res_nxt.state_now    = state_nxt;
    res_nxt.queue_count  = 5'(fill_nxt);
    res_nxt.repeat_count = rep_nxt;
    res_nxt.sent_packets = sent_pkt_nxt;
    res_nxt.sent_bits    = sent_bits_nxt;
    res_nxt.lost_packets = lost_nxt;
    res_nxt.ack_count    = ack_nxt;
    res_nxt.nack_count   = nack_nxt;

    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= 5'd16;
      header_bits_r <= 10'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        sawarq_pkg::REG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata[4:0];
        sawarq_pkg::REG_HEADER_BITS: header_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sawarq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      seq_r       <= '0;
      tag_r       <= '0;
      bits_r      <= '0;
      rep_r       <= '0;
      sent_pkt_r  <= '0;
      sent_bits_r <= '0;
      lost_r      <= '0;
      ack_r       <= '0;
      nack_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r     <= state_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        fill_r      <= fill_nxt;
        seq_r       <= seq_nxt;
        tag_r       <= tag_nxt;
        bits_r      <= bits_nxt;
        rep_r       <= rep_nxt;
        sent_pkt_r  <= sent_pkt_nxt;
        sent_bits_r <= sent_bits_nxt;
        lost_r      <= lost_nxt;
        ack_r       <= ack_nxt;
        nack_r      <= nack_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_nxt;
    if (fire && do_push) begin
      pend_tag_r[tail_r]  <= evt.tag;
      pend_bits_r[tail_r] <= evt.bits;
    end
  end

  `SAW_ASSERT(a_back_fill_max, fill_r <= sawarq_pkg::fill_t'(sawarq_pkg::QUEUE_DEPTH), "fill overflow")
  `SAW_ASSERT(a_back_empty_ptrs, (fill_r != '0) || (head_r == tail_r), "empty queue ptr mismatch")
  `SAW_ASSERT_NEXT(a_back_send_state, fire && (act == sawarq_pkg::ACT_SEND), state_r == sawarq_pkg::ST_SENDING, "send without sending state")
  `SAW_ASSERT_NEXT(a_back_txdone, fire && evt.is_txdone && (state_r == sawarq_pkg::ST_SENDING), state_r == sawarq_pkg::ST_WAITING, "transmit done not taken")

endmodule

/* rtl/stop_and_wait_arq_sender_core.sv */
// Stop-and-wait ARQ sender: on each link event, emits one status beat.
//
// Input stream: one beat per link event (new packet, transmit done, ACK,
// NACK); the event kind rides on in_tuser. Output stream: exactly one beat
// per input beat, in order, with the action taken, the frame to (re)send
// and the running statistics counters.
// Throughput: one event per cycle while out_tready is high. Each beat
// passes through the event queue and then the result register on its way
// to the output. The rate is set by the back end's state update, which
// handles each event in the cycle it leaves the queue.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at the next edge;
// the user must make them only while no event is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the event queue and pending
// packet queue, sets the link idle, clears all counters and restores
// queue_limit to 16 and header_bits to 0.
// When out_tready is low the result register holds its beat; the back
// end stalls, the two-entry event queue fills and then in_tready drops.
module stop_and_wait_arq_sender_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // packet_tag[15:0], packet_bits[31:16], ack_seq_in[47:32]
  input  logic [7:0]   in_tuser,   // opcode[1:0], zero above
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [231:0] out_tdata,  // frame_seq[15:0], frame_tag[31:16], frame_bits[48:32],
                                   // state_now[50:49], queue_count[55:51],
                                   // repeat_count[71:56], sent_packets[103:72],
                                   // sent_bits[135:104], lost_packets[167:136],
                                   // ack_count[199:168], nack_count[231:200]
  output logic [7:0]   out_tuser,  // action[1:0], zero above
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [9:0]   cfg_wdata
);

  logic                evt_valid;
  logic                evt_ready;
  sawarq_pkg::evt_t    evt;
  sawarq_pkg::result_t res;

  sawarq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  sawarq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tuser = {6'd0, res.action};
  assign out_tdata = {res.nack_count, res.ack_count, res.lost_packets, res.sent_bits,
                      res.sent_packets, res.repeat_count, res.queue_count, res.state_now,
                      res.frame_bits, res.frame_tag, res.frame_seq};

endmodule
